[src/hkf_pkg.sv]
`default_nettype none

package hkf_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 47;

	localparam int SP_W   = 37;
	localparam int GRAV_W = 41;
	localparam int RN_W   = 47;
	localparam int PN_W   = 37;

	localparam logic [SP_W-1:0]   SP_RESET   = 37'd68719477;
	localparam logic [GRAV_W-1:0] GRAV_RESET = 41'd674138066780;
	localparam logic [RN_W-1:0]   RN_RESET   = 47'd2061584302080;
	localparam logic [PN_W-1:0]   PN_RESET   = 37'd68719477;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_PERIOD,
		CFG_GRAVITY,
		CFG_MEAS_NOISE,
		CFG_PROC_NOISE
	} cfg_idx_t;

	// top-level sequencer
	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_ISSUE,
		SQ_WAIT,
		SQ_DONE
	} seq_state_t;

	// one shared-unit operation per step
	typedef enum logic [4:0] {
		ST_TXAX,
		ST_TYAY,
		ST_TZAZ,
		ST_B1,
		ST_B0,
		ST_X0B,
		ST_M00,
		ST_M01,
		ST_PB00,
		ST_G0,
		ST_G1,
		ST_POS,
		ST_VEL,
		ST_C0,
		ST_C1,
		ST_C2,
		ST_C3
	} step_t;

	// shared arithmetic unit
	typedef enum logic [1:0] {
		AS_IDLE,
		AS_MUL,
		AS_DIV,
		AS_FIN
	} alu_state_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

`default_nettype wire

[src/hkf_in_if.sv]
`default_nettype none

interface hkf_in_if #(
	parameter int DW = 48,
	parameter int TW = 38
) ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] measured_height;
	logic signed [DW-1:0] accel_x;
	logic signed [DW-1:0] accel_y;
	logic signed [DW-1:0] accel_z;
	logic signed [TW-1:0] tilt_row_x;
	logic signed [TW-1:0] tilt_row_y;
	logic signed [TW-1:0] tilt_row_z;

	modport source (
		output valid, measured_height, accel_x, accel_y, accel_z,
		       tilt_row_x, tilt_row_y, tilt_row_z,
		input  ready
	);
	modport sink (
		input  valid, measured_height, accel_x, accel_y, accel_z,
		       tilt_row_x, tilt_row_y, tilt_row_z,
		output ready
	);
endinterface

`default_nettype wire

[src/hkf_out_if.sv]
`default_nettype none

interface hkf_out_if #(
	parameter int DW = 48
) ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] height_estimate;
	logic signed [DW-1:0] velocity_estimate;

	modport source (output valid, height_estimate, velocity_estimate, input ready);
	modport sink (input valid, height_estimate, velocity_estimate, output ready);
endinterface

`default_nettype wire

[src/hkf_cfg_if.sv]
`default_nettype none

interface hkf_cfg_if ();
	import hkf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/hkf_alu.sv]
`default_nettype none

module hkf_alu #(
	parameter int DW   = 48,
	parameter int FRAC = 36
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hkf_pkg::alu_req_t    req,
	input  logic signed [DW-1:0] opa,
	input  logic signed [DW-1:0] opb,
	output logic                 done,
	output logic signed [DW-1:0] result
);
	import hkf_pkg::*;

	localparam int DIG  = 8;
	localparam int PW   = 2 * DW;
	localparam int NDIG = (DW + DIG - 1) / DIG;
	localparam int YW   = NDIG * DIG;
	localparam int NW   = DW + FRAC;
	localparam int CW   = $clog2(NW + 1);

	localparam logic [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [PW:0]   HALF = (PW+1)'(1) << (FRAC - 1);

	alu_state_t      state_q, state_d;
	alu_op_t         op_q;
	logic            neg_q;
	logic            zden_q;
	logic            done_q;
	logic [PW-1:0]   x_q;
	logic [YW-1:0]   y_q;
	logic [PW-1:0]   p_q;
	logic [DW-1:0]   d_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   nq_q;
	logic [CW-1:0]   cnt_q;
	logic [DW-1:0]   res_q;

	logic [DW-1:0]   mag_a, mag_b;
	logic [DW:0]     trial, trial_sub;
	logic            trial_ge;
	logic [PW:0]     rnd;
	logic            fin_ovf;
	logic [DW-1:0]   fin_mag;
	logic [DW-1:0]   fin_res;

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : v;
	endfunction

	assign mag_a = mag(opa);
	assign mag_b = mag(opb);

	// restoring divide, one quotient bit a cycle
	assign trial     = {rem_q, nq_q[NW-1]};
	assign trial_ge  = trial >= {1'b0, d_q};
	assign trial_sub = trial - {1'b0, d_q};

	// round half away from zero on the magnitude, then saturate
	assign rnd = ({1'b0, p_q} + HALF) >> FRAC;

	always_comb begin
		if (op_q == OP_MUL) begin
			fin_ovf = |rnd[PW:DW];
			fin_mag = rnd[DW-1:0];
		end else begin
			fin_ovf = |nq_q[NW-1:DW];
			fin_mag = nq_q[DW-1:0];
		end
		if (fin_ovf) begin
			fin_res = neg_q ? WMIN : WMAX;
		end else if (!neg_q) begin
			fin_res = fin_mag[DW-1] ? WMAX : fin_mag;
		end else if (fin_mag[DW-1] && |fin_mag[DW-2:0]) begin
			fin_res = WMIN;
		end else begin
			fin_res = DW'(-fin_mag);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			AS_IDLE: begin
				if (req.start) begin
					if (req.op == OP_MUL) begin
						state_d = AS_MUL;
					end else if (opb == '0) begin
						state_d = AS_FIN;
					end else begin
						state_d = AS_DIV;
					end
				end
			end
			AS_MUL: begin
				if (cnt_q == CW'(NDIG - 1)) state_d = AS_FIN;
			end
			AS_DIV: begin
				if (cnt_q == CW'(NW - 1)) state_d = AS_FIN;
			end
			AS_FIN: begin
				state_d = AS_IDLE;
			end
			default: state_d = AS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == AS_FIN);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			AS_IDLE: begin
				if (req.start) begin
					op_q   <= req.op;
					neg_q  <= opa[DW-1] ^ opb[DW-1];
					cnt_q  <= '0;
					zden_q <= (opb == '0);
					x_q    <= PW'(mag_a);
					y_q    <= YW'(mag_b);
					p_q    <= '0;
					d_q    <= mag_b;
					rem_q  <= '0;
					nq_q   <= NW'(mag_a) << FRAC;
					// zero denominator: saturate by numerator sign
					if (opa[DW-1]) begin
						res_q <= WMIN;
					end else if (opa != '0) begin
						res_q <= WMAX;
					end else begin
						res_q <= '0;
					end
				end
			end
			AS_MUL: begin
				p_q   <= p_q + x_q * PW'(y_q[DIG-1:0]);
				x_q   <= x_q << DIG;
				y_q   <= y_q >> DIG;
				cnt_q <= cnt_q + CW'(1);
			end
			AS_DIV: begin
				rem_q <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
				nq_q  <= {nq_q[NW-2:0], trial_ge};
				cnt_q <= cnt_q + CW'(1);
			end
			AS_FIN: begin
				if (!(op_q == OP_DIV && zden_q)) res_q <= fin_res;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

`default_nettype wire

[src/height_kalman_filter.sv]
`default_nettype none

// Vertical height estimator: a two-state (height, vertical velocity) Kalman
// filter in signed fixed point with FRAC_BITS fraction bits in DATA_WIDTH-bit
// words (Q12.36 in 48 bits by default). Each item on meas carries a height
// measurement, body-frame acceleration and the third row of the tilt matrix;
// one item leaves on est with the corrected height and velocity. The first
// item after reset seeds height from the measurement with zero velocity.
// All arithmetic runs through one shared unit: an 8-bit-digit multiplier
// and a one-bit-a-cycle restoring divider. An item takes 15 multiplies and
// 2 divides; meas is not ready meanwhile. A finished result sits in an
// output register; the next item is taken while it waits. Configuration
// writes (cfg) are always accepted and must only arrive while the block
// is idle.
module height_kalman_filter #(
	parameter int DATA_WIDTH = 48,
	parameter int FRAC_BITS  = 36
) (
	input  logic  clk,
	input  logic  arst_n,
	hkf_cfg_if.sink  cfg,
	hkf_in_if.sink   meas,
	hkf_out_if.source est
);
	import hkf_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int TW = FRAC_BITS + 2;
	localparam int XW = ((TW > DW) ? TW : DW) + 1;
	localparam int EW = ((CFG_DATA_W > DW) ? CFG_DATA_W : DW) + 1;

	localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};

	typedef logic signed [DW-1:0] word_t;

	// saturating add / subtract
	function automatic word_t sadd(input word_t a, input word_t b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? WMIN : WMAX;
		return s[DW-1:0];
	endfunction

	function automatic word_t ssub(input word_t a, input word_t b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		if (s[DW] != s[DW-1]) return s[DW] ? WMIN : WMAX;
		return s[DW-1:0];
	endfunction

	// unsigned register value clamped to the signed word range
	function automatic word_t cfg_sat(input logic [CFG_DATA_W-1:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		if (e > EW'(WMAX)) return WMAX;
		return e[DW-1:0];
	endfunction

	// tilt element sign-extended, clamped where it is wider than a word
	function automatic word_t tilt_sat(input logic signed [TW-1:0] t);
		logic signed [XW-1:0] e;
		e = XW'(t);
		if (e > XW'(WMAX)) return WMAX;
		if (e < XW'(WMIN)) return WMIN;
		return e[DW-1:0];
	endfunction

	// configuration registers
	logic [SP_W-1:0]   sp_q;
	logic [GRAV_W-1:0] grav_q;
	logic [RN_W-1:0]   rn_q;
	logic [PN_W-1:0]   pn_q;
	word_t dt, grav, rn, pn;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= SP_RESET;
			grav_q <= GRAV_RESET;
			rn_q   <= RN_RESET;
			pn_q   <= PN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_SAMPLE_PERIOD: sp_q   <= cfg.data[SP_W-1:0];
				CFG_GRAVITY:       grav_q <= cfg.data[GRAV_W-1:0];
				CFG_MEAS_NOISE:    rn_q   <= cfg.data[RN_W-1:0];
				CFG_PROC_NOISE:    pn_q   <= cfg.data[PN_W-1:0];
				default: ;
			endcase
		end
	end

	assign dt   = cfg_sat(CFG_DATA_W'(sp_q));
	assign grav = cfg_sat(CFG_DATA_W'(grav_q));
	assign rn   = cfg_sat(CFG_DATA_W'(rn_q));
	assign pn   = cfg_sat(CFG_DATA_W'(pn_q));

	// sequencer
	seq_state_t state_q, state_d;
	step_t      step_q;
	alu_req_t   req;
	logic       alu_done;
	word_t      r;
	word_t      opa, opb;
	logic       accept;

	// filter state
	logic  first_q;
	word_t pos_q, vel_q, c0_q, c1_q, c2_q, c3_q;
	// captured item
	word_t z_q, ax_q, ay_q, az_q, tx_q, ty_q, tz_q;
	// intermediates
	word_t t_q, b1_q, b0_q, x0b_q, x1b_q, m00_q, m01_q, pb00_q, pb10_q, pb11_q;
	word_t s_q, g0_q, g1_q, innov_q;
	word_t x0b_new, pb00_new;
	// result register
	logic  out_valid_q;
	word_t out_h_q, out_v_q;

	assign accept     = meas.valid && meas.ready;
	assign meas.ready = (state_q == SQ_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE:  if (meas.valid) state_d = SQ_ISSUE;
			SQ_ISSUE: state_d = SQ_WAIT;
			SQ_WAIT: begin
				if (alu_done) state_d = (step_q == ST_C3) ? SQ_DONE : SQ_ISSUE;
			end
			SQ_DONE: if (!out_valid_q || est.ready) state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	// operand select per step; one start pulse per step
	always_comb begin
		req.start = (state_q == SQ_ISSUE);
		req.op    = OP_MUL;
		opa       = tx_q;
		opb       = ax_q;
		unique case (step_q)
			ST_TXAX: begin opa = tx_q;   opb = ax_q;   end
			ST_TYAY: begin opa = ty_q;   opb = ay_q;   end
			ST_TZAZ: begin opa = tz_q;   opb = az_q;   end
			ST_B1:   begin opa = t_q;    opb = dt;     end
			ST_B0:   begin opa = b1_q;   opb = dt;     end
			ST_X0B:  begin opa = dt;     opb = vel_q;  end
			ST_M00:  begin opa = dt;     opb = c2_q;   end
			ST_M01:  begin opa = dt;     opb = c3_q;   end
			ST_PB00: begin opa = dt;     opb = m01_q;  end
			ST_G0:   begin opa = pb00_q; opb = s_q;    req.op = OP_DIV; end
			ST_G1:   begin opa = pb10_q; opb = s_q;    req.op = OP_DIV; end
			ST_POS:  begin opa = g0_q;   opb = innov_q; end
			ST_VEL:  begin opa = g1_q;   opb = innov_q; end
			ST_C0:   begin opa = g0_q;   opb = pb00_q; end
			ST_C1:   begin opa = g0_q;   opb = m01_q;  end
			ST_C2:   begin opa = g1_q;   opb = pb00_q; end
			ST_C3:   begin opa = g1_q;   opb = m01_q;  end
			default: ;
		endcase
	end

	hkf_alu #(
		.DW   (DW),
		.FRAC (FRAC_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.done   (alu_done),
		.result (r)
	);

	assign x0b_new  = sadd(sadd(pos_q, r), b0_q);
	assign pb00_new = sadd(sadd(m00_q, r), pn);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			step_q      <= ST_TXAX;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			vel_q       <= '0;
			c0_q        <= '0;
			c1_q        <= '0;
			c2_q        <= '0;
			c3_q        <= '0;
		end else begin
			state_q <= state_d;

			if (accept) begin
				step_q <= ST_TXAX;
				// first item: seed height, zero velocity and variances
				if (first_q) begin
					pos_q   <= meas.measured_height;
					vel_q   <= '0;
					c0_q    <= '0;
					c3_q    <= '0;
					first_q <= 1'b0;
				end
			end

			if (state_q == SQ_WAIT && alu_done) begin
				if (step_q != ST_C3) step_q <= step_t'(step_q + 5'd1);
				unique case (step_q)
					ST_POS: pos_q <= sadd(x0b_q, r);
					ST_VEL: vel_q <= sadd(x1b_q, r);
					ST_C0:  c0_q  <= ssub(pb00_q, r);
					ST_C1:  c1_q  <= ssub(m01_q, r);
					ST_C2:  c2_q  <= ssub(pb10_q, r);
					ST_C3:  c3_q  <= ssub(pb11_q, r);
					default: ;
				endcase
			end

			if (state_q == SQ_DONE && state_d == SQ_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (est.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and intermediates
	always_ff @(posedge clk) begin
		if (accept) begin
			z_q  <= meas.measured_height;
			ax_q <= meas.accel_x;
			ay_q <= meas.accel_y;
			az_q <= meas.accel_z;
			tx_q <= tilt_sat(meas.tilt_row_x);
			ty_q <= tilt_sat(meas.tilt_row_y);
			tz_q <= tilt_sat(meas.tilt_row_z);
		end

		if (state_q == SQ_WAIT && alu_done) begin
			unique case (step_q)
				ST_TXAX: t_q <= r;
				ST_TYAY: t_q <= sadd(t_q, r);
				// vertical acceleration less gravity
				ST_TZAZ: t_q <= ssub(sadd(t_q, r), grav);
				ST_B1:   b1_q <= r;
				ST_B0:   b0_q <= r;
				ST_X0B: begin
					x0b_q   <= x0b_new;
					x1b_q   <= sadd(vel_q, b1_q);
					innov_q <= ssub(z_q, x0b_new);
				end
				ST_M00:  m00_q <= sadd(c0_q, r);
				ST_M01: begin
					m01_q  <= sadd(c1_q, r);
					pb10_q <= sadd(c2_q, r);
					pb11_q <= sadd(c3_q, pn);
				end
				ST_PB00: begin
					pb00_q <= pb00_new;
					s_q    <= sadd(pb00_new, rn);
				end
				ST_G0:   g0_q <= r;
				ST_G1:   g1_q <= r;
				default: ;
			endcase
		end

		if (state_q == SQ_DONE && state_d == SQ_IDLE) begin
			out_h_q <= pos_q;
			out_v_q <= vel_q;
		end
	end

	assign est.valid             = out_valid_q;
	assign est.height_estimate   = out_h_q;
	assign est.velocity_estimate = out_v_q;

endmodule

`default_nettype wire
